[sv/mvm_pkg.sv]
// ----------------------------------------------------------------------------
// mvm_pkg
// shared constants and types for the matrix-vector multiply block
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int MAX_COLS = 256;
	localparam int MAX_ROWS = 256;

	localparam int DATA_W  = 64;
	localparam int HALF_W  = DATA_W / 2;
	localparam int VEC_AW  = $clog2(MAX_COLS);
	localparam int COL_W   = $clog2(MAX_COLS);
	localparam int ROW_W   = $clog2(MAX_ROWS);
	localparam int CNT_W   = 9;
	localparam int IDX_W   = 8;

	typedef logic [DATA_W-1:0] data_t;
	typedef logic [VEC_AW-1:0] vec_addr_t;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_MATRIX = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_COL_COUNT = 1'b0,
		REG_ROW_COUNT = 1'b1
	} reg_index_t;

endpackage

[sv/matrix_vector_multiply_top.sv]
// ----------------------------------------------------------------------------
// matrix_vector_multiply_top
// streaming dense matrix-vector product, modulo 2^64
// ----------------------------------------------------------------------------
// input channel (in_valid / in_stall): opcode OP_LOAD writes operand_value
// into the vector store at vec_index; opcode OP_MATRIX supplies the next
// element of A in row-major order. one transaction per cycle unless in_stall.
// output channel (out_valid / out_stall): one transaction per matrix row,
// carrying row_index, row_sum and last_row on the final row.
// config channel (cfg_valid / cfg_ready): cfg_index selects col_count or
// row_count, cfg_data is the new count; write only while the block is idle.
// pipeline: a row result passes through the vector store read, two multiplier
// stages and the accumulate into the output register after its last matrix
// element is accepted. throughput: one item per cycle while in_stall is low, set
// by the vector store's single read port and the pipelined 64-bit multiplier.
// reset: counters and accumulator clear, both counts return to 256; the
// vector store is not cleared and must be loaded before use.
// stall: a skid register behind the output register absorbs one result;
// only once it is occupied does in_stall rise and the pipeline hold.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [7:0]  vec_index,
	input  logic [63:0] operand_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  row_index,
	output logic [63:0] row_sum,
	output logic        last_row,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [8:0]  cfg_data
);

	typedef struct packed {
		logic                       valid;
		logic                       row_end;
		logic                       last;
		logic [mvm_pkg::IDX_W-1:0]  row_idx;
	} ctl_t;

	logic                        adv;
	logic                        in_acc;
	logic                        mat_acc;
	logic                        ld_acc;
	logic [mvm_pkg::CNT_W-1:0]   col_count_q;
	logic [mvm_pkg::CNT_W-1:0]   row_count_q;
	logic [mvm_pkg::CNT_W-1:0]   cols_eff;
	logic [mvm_pkg::CNT_W-1:0]   rows_eff;
	logic [mvm_pkg::COL_W-1:0]   col_cnt_q;
	logic [mvm_pkg::ROW_W-1:0]   row_cnt_q;
	logic                        row_end;
	logic                        last;
	ctl_t                        ctl_s1;
	ctl_t                        ctl_s2;
	ctl_t                        ctl_s3;
	mvm_pkg::data_t              value_s1;
	mvm_pkg::data_t              vec_data;
	mvm_pkg::data_t              prod;
	mvm_pkg::data_t              acc_q;
	mvm_pkg::data_t              sum;
	logic                        push;
	logic                        out_valid_q;
	logic [mvm_pkg::IDX_W-1:0]   out_idx_q;
	mvm_pkg::data_t              out_sum_q;
	logic                        out_last_q;
	logic                        skid_valid_q;
	logic [mvm_pkg::IDX_W-1:0]   skid_idx_q;
	mvm_pkg::data_t              skid_sum_q;
	logic                        skid_last_q;

	// config registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS);
			row_count_q <= mvm_pkg::CNT_W'(mvm_pkg::MAX_ROWS);
		end else if (cfg_valid && cfg_ready) begin
			case (mvm_pkg::reg_index_t'(cfg_index))
				mvm_pkg::REG_COL_COUNT: col_count_q <= cfg_data;
				mvm_pkg::REG_ROW_COUNT: row_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// zero acts as one, above the maximum acts as the maximum
	always_comb begin
		if (col_count_q == '0) begin
			cols_eff = mvm_pkg::CNT_W'(1);
		end else if (32'(col_count_q) > mvm_pkg::MAX_COLS) begin
			cols_eff = mvm_pkg::CNT_W'(mvm_pkg::MAX_COLS);
		end else begin
			cols_eff = col_count_q;
		end
		if (row_count_q == '0) begin
			rows_eff = mvm_pkg::CNT_W'(1);
		end else if (32'(row_count_q) > mvm_pkg::MAX_ROWS) begin
			rows_eff = mvm_pkg::CNT_W'(mvm_pkg::MAX_ROWS);
		end else begin
			rows_eff = row_count_q;
		end
	end

	// input side
	assign adv      = !skid_valid_q;
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;
	assign mat_acc  = in_acc && (mvm_pkg::opcode_t'(opcode) == mvm_pkg::OP_MATRIX);
	assign ld_acc   = in_acc && (mvm_pkg::opcode_t'(opcode) == mvm_pkg::OP_LOAD)
		&& (32'(vec_index) < mvm_pkg::MAX_COLS);

	assign row_end = (mvm_pkg::CNT_W'(col_cnt_q) + mvm_pkg::CNT_W'(1)) >= cols_eff;
	assign last    = (mvm_pkg::CNT_W'(row_cnt_q) + mvm_pkg::CNT_W'(1)) >= rows_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (mat_acc) begin
			if (row_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= last ? '0 : row_cnt_q + mvm_pkg::ROW_W'(1);
			end else begin
				col_cnt_q <= col_cnt_q + mvm_pkg::COL_W'(1);
			end
		end
	end

	mvm_vec_ram u_vec_ram (
		.clk   (clk),
		.we    (ld_acc),
		.waddr (mvm_pkg::VEC_AW'(vec_index)),
		.wdata (operand_value),
		.re    (mat_acc),
		.raddr (mvm_pkg::VEC_AW'(col_cnt_q)),
		.rdata (vec_data)
	);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (adv) begin
			ctl_s1.valid   <= mat_acc;
			ctl_s1.row_end <= row_end;
			ctl_s1.last    <= last;
			ctl_s1.row_idx <= mvm_pkg::IDX_W'(row_cnt_q);
			ctl_s2         <= ctl_s1;
			ctl_s3         <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mat_acc) begin
			value_s1 <= operand_value;
		end
	end

	mvm_mul64 u_mul (
		.clk (clk),
		.en  (adv),
		.a   (value_s1),
		.b   (vec_data),
		.p   (prod)
	);

	// accumulate
	assign sum  = acc_q + prod;
	assign push = adv && ctl_s3.valid && ctl_s3.row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (adv && ctl_s3.valid) begin
			acc_q <= ctl_s3.row_end ? '0 : sum;
		end
	end

	// output register with skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_idx_q  <= skid_idx_q;
				out_sum_q  <= skid_sum_q;
				out_last_q <= skid_last_q;
			end else if (push) begin
				out_idx_q  <= ctl_s3.row_idx;
				out_sum_q  <= sum;
				out_last_q <= ctl_s3.last;
			end
		end else if (push) begin
			skid_idx_q  <= ctl_s3.row_idx;
			skid_sum_q  <= sum;
			skid_last_q <= ctl_s3.last;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = out_idx_q;
	assign row_sum   = out_sum_q;
	assign last_row  = out_last_q;

	// checks
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	a_col_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_acc && row_end) |=> (col_cnt_q == '0))
		else $error("column counter not cleared at end of row");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(mat_acc && row_end && last) |=> (row_cnt_q == '0))
		else $error("row counter not cleared after final row");

	a_no_push_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && out_stall) |=> (skid_valid_q && $stable(out_sum_q)))
		else $error("result lost while output stalled");

endmodule

[sv/mvm_vec_ram.sv]
// ----------------------------------------------------------------------------
// mvm_vec_ram
// vector store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module mvm_vec_ram (
	input  logic              clk,
	input  logic              we,
	input  mvm_pkg::vec_addr_t waddr,
	input  mvm_pkg::data_t     wdata,
	input  logic              re,
	input  mvm_pkg::vec_addr_t raddr,
	output mvm_pkg::data_t     rdata
);

	mvm_pkg::data_t mem [mvm_pkg::MAX_COLS];
	mvm_pkg::data_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

[sv/mvm_mul64.sv]
// ----------------------------------------------------------------------------
// mvm_mul64
// low 64 bits of a 64x64 product, two stages: 32x32 partial products, then their sum
// ----------------------------------------------------------------------------
module mvm_mul64 (
	input  logic           clk,
	input  logic           en,
	input  mvm_pkg::data_t a,
	input  mvm_pkg::data_t b,
	output mvm_pkg::data_t p
);

	localparam int HW = mvm_pkg::HALF_W;

	mvm_pkg::data_t     ll_s1;
	logic [HW-1:0]      lh_s1;
	logic [HW-1:0]      hl_s1;
	mvm_pkg::data_t     p_s2;
	logic [HW-1:0]      mid_sum;

	always_ff @(posedge clk) begin
		if (en) begin
			ll_s1 <= mvm_pkg::DATA_W'(a[HW-1:0]) * mvm_pkg::DATA_W'(b[HW-1:0]);
			lh_s1 <= HW'(a[HW-1:0] * b[2*HW-1:HW]);
			hl_s1 <= HW'(a[2*HW-1:HW] * b[HW-1:0]);
		end
	end

	assign mid_sum = lh_s1 + hl_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s2 <= ll_s1 + {mid_sum, {HW{1'b0}}};
		end
	end

	assign p = p_s2;

endmodule
